/* design/owcrc_pkg.sv */
package owcrc_pkg;

  localparam logic [7:0] CRC_POLY      = 8'h8c;
  localparam int         HIGH_PREC_BIT = 7;
  localparam logic [3:0] COUNT_MAX     = 4'd15;
  localparam logic [3:0] IDX_TEMP_LSB  = 4'd0;
  localparam logic [3:0] IDX_TEMP_MSB  = 4'd1;
  localparam logic [3:0] IDX_CONFIG    = 4'd4;
  localparam logic [3:0] IDX_CRC_LAST  = 4'd8;
  localparam int         TEMP_W        = 19;
  localparam int         LEGACY_SHIFT  = 3;

  typedef enum logic {
    KIND_PLAIN      = 1'b0,
    KIND_SCRATCHPAD = 1'b1
  } frame_kind_t;

  // Reflected CRC-8 over one byte, one bit per step.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Temperature in 1/128 degree units; legacy format scales by 8.
  function automatic logic signed [TEMP_W-1:0] temp_code(input logic [7:0] lo,
                                                         input logic [7:0] hi,
                                                         input logic       hp);
    logic signed [TEMP_W-1:0] v;
    v = TEMP_W'($signed({hi, lo}));
    if (!hp) begin
      v = v <<< LEGACY_SHIFT;
    end
    return v;
  endfunction

endpackage

/* design/onewire_frame_crc_temp_checker.sv */
// 1-Wire frame checker with scratchpad temperature extraction.
//
// Input channel (in_*): one received byte per request; in_tuser carries the
// frame mode (0 plain CRC check, 1 nine-byte scratchpad), sampled on the
// first byte of a frame, and in_tlast marks the final byte, which is the CRC.
// Output channel (out_*): one result per final byte, none for other bytes.
//
// Throughput is one byte per cycle while in_tready is high: the byte-wide
// CRC-8 update, the byte capture and the result build all sit between the
// accepted request and the state/result registers. out_tvalid rises in the
// cycle after the final byte is accepted.
//
// The result register doubles as the skid stage: a new byte is taken while
// a result waits, as long as that result is being taken in the same cycle or
// the register is empty. A stalled receiver therefore holds off the input
// only while a result is pending and not accepted.
//
// Reset (rst_n low, synchronous) clears the CRC, the byte count, the frame
// kind, the captured temperature bytes and the result valid flag; the result data is not reset.
module onewire_frame_crc_temp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] crc_ok, [1] length_ok, [20:2] temperature,
                                  // [21] temp_valid, [23:22] zero
);

  logic [7:0]                              crc_r, crc_nxt;
  logic [3:0]                              count_r, count_nxt;
  owcrc_pkg::frame_kind_t                  kind_r, kind_nxt, kind_cur;
  logic [7:0]                              tlo_r, tlo_nxt;
  logic [7:0]                              thi_r, thi_nxt;
  logic                                    hp_r, hp_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  logic [23:0]                             out_data_r, out_data_nxt;
  logic                                    in_fire;
  logic                                    crc_ok, len_ok, temp_ok;
  logic signed [owcrc_pkg::TEMP_W-1:0]     temp_val;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    kind_cur = (count_r == 4'd0) ? owcrc_pkg::frame_kind_t'(in_tuser) : kind_r;
    crc_ok   = (in_tdata == crc_r);
    len_ok   = (kind_cur == owcrc_pkg::KIND_PLAIN) || (count_r == owcrc_pkg::IDX_CRC_LAST);
    temp_ok  = (kind_cur == owcrc_pkg::KIND_SCRATCHPAD) && len_ok && crc_ok;
    temp_val = temp_ok ? owcrc_pkg::temp_code(tlo_r, thi_r, hp_r) : '0;
  end

  always_comb begin
    crc_nxt       = crc_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    tlo_nxt       = tlo_r;
    thi_nxt       = thi_r;
    hp_nxt        = hp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      kind_nxt = kind_cur;
      if (!in_tlast) begin
        crc_nxt = owcrc_pkg::crc8_update(crc_r, in_tdata);
        if (kind_cur == owcrc_pkg::KIND_SCRATCHPAD) begin
          if (count_r == owcrc_pkg::IDX_TEMP_LSB) begin
            tlo_nxt = in_tdata;
          end else if (count_r == owcrc_pkg::IDX_TEMP_MSB) begin
            thi_nxt = in_tdata;
          end else if (count_r == owcrc_pkg::IDX_CONFIG) begin
            hp_nxt = in_tdata[owcrc_pkg::HIGH_PREC_BIT];
          end
        end
        if (count_r != owcrc_pkg::COUNT_MAX) begin
          count_nxt = count_r + 4'd1;
        end
      end else begin
        // close the frame and load the result
        crc_nxt       = '0;
        count_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = {2'b00, temp_ok, temp_val, len_ok, crc_ok};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      count_r     <= '0;
      kind_r      <= owcrc_pkg::KIND_PLAIN;
      tlo_r       <= '0;
      thi_r       <= '0;
      hp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      kind_r      <= kind_nxt;
      tlo_r       <= tlo_nxt;
      thi_r       <= thi_nxt;
      hp_r        <= hp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_valid_needs_checks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[0] && out_tdata[1])
    else $error("temp_valid without CRC and length match");

  a_temp_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[21] |-> out_tdata[20:2] == '0)
    else $error("temperature not zero on invalid result");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> count_r == '0 && crc_r == '0 && out_valid_r)
    else $error("frame state not cleared or result missing after last byte");

  a_no_result_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tlast && !out_valid_r |=> !out_valid_r)
    else $error("result raised by a non-final byte");

endmodule

/* tb/sv/tb_onewire_frame_crc_temp_checker.sv */
`timescale 1ns / 1ps

module tb_onewire_frame_crc_temp_checker;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic                                crc_ok;
    logic                                length_ok;
    logic signed [owcrc_pkg::TEMP_W-1:0] temperature;
    logic                                temp_valid;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] mode
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [0] crc_ok, [1] length_ok, [20:2] temperature,
                                   // [21] temp_valid, [23:22] zero

  onewire_frame_crc_temp_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the frame state
  logic [7:0]             sh_crc = 8'h00;
  logic [3:0]             sh_count = 4'd0;
  owcrc_pkg::frame_kind_t sh_kind = owcrc_pkg::KIND_PLAIN;
  logic [7:0]             sh_lo = 8'h00;
  logic [7:0]             sh_hi = 8'h00;
  logic                   sh_hp = 1'b0;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  int       items_sent = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;
  logic     hold_tog = 1'b0;
  logic     hold_seen = 1'b0;

  // Reflected CRC-8, folded one input bit at a time, LSB first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ owcrc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_crc(input byte_q_t body);
    logic [7:0] c;
    c = 8'h00;
    foreach (body[i]) begin
      c = crc8_fold(c, body[i]);
    end
    return c;
  endfunction

  // Fold one accepted request into the shadow state; a final byte yields a verdict.
  task automatic predict_frame_verdict(input logic mode, input logic [7:0] b,
                                       input logic last);
    logic [3:0] idx;
    verdict_t   v;
    idx = sh_count;
    if (idx == 4'd0) begin
      sh_kind = owcrc_pkg::frame_kind_t'(mode);
    end
    if (!last) begin
      sh_crc = crc8_fold(sh_crc, b);
      if (sh_kind == owcrc_pkg::KIND_SCRATCHPAD) begin
        if (idx == owcrc_pkg::IDX_TEMP_LSB) begin
          sh_lo = b;
        end else if (idx == owcrc_pkg::IDX_TEMP_MSB) begin
          sh_hi = b;
        end else if (idx == owcrc_pkg::IDX_CONFIG) begin
          sh_hp = b[owcrc_pkg::HIGH_PREC_BIT];
        end
      end
      if (sh_count != owcrc_pkg::COUNT_MAX) begin
        sh_count = sh_count + 4'd1;
      end
    end else begin
      v.crc_ok      = (b == sh_crc);
      v.length_ok   = (sh_kind == owcrc_pkg::KIND_PLAIN) || (idx == owcrc_pkg::IDX_CRC_LAST);
      v.temp_valid  = (sh_kind == owcrc_pkg::KIND_SCRATCHPAD) && v.length_ok && v.crc_ok;
      v.temperature = '0;
      if (v.temp_valid) begin
        // high-precision format: raw, sign-extended; legacy format: raw times eight
        v.temperature = sh_hp ? {{3{sh_hi[7]}}, sh_hi, sh_lo} : {sh_hi, sh_lo, 3'b000};
      end
      pending_verdicts.push_back(v);
      sh_crc   = 8'h00;
      sh_count = 4'd0;
    end
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // Offer one request and hold it until taken; valid stays high afterwards.
  task automatic push_byte(input logic mode, input logic [7:0] b, input logic last);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame_verdict(mode, b, last);
    items_sent++;
  endtask

  // Mode only counts on the first byte; scramble it on the rest.
  task automatic push_frame(input logic kind, input byte_q_t body, input logic spoil);
    logic [7:0] crc;
    crc = frame_crc(body);
    if (spoil) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    foreach (body[i]) begin
      push_byte((i == 0) ? kind : 1'($urandom_range(1)), body[i], 1'b0);
    end
    push_byte((body.size() == 0) ? kind : 1'($urandom_range(1)), crc, 1'b1);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    byte_q_t body;
    gap_pct   = 0;
    stall_pct = 0;
    // single-byte frames: compared against a zero CRC
    body = {};
    push_frame(owcrc_pkg::KIND_PLAIN, body, 1'b0);
    push_byte(owcrc_pkg::KIND_SCRATCHPAD, 8'hff, 1'b1);
    // most negative reading, high-precision format
    body = {8'h00, 8'h80, 8'h4b, 8'h46, 8'h80, 8'hff, 8'h00, 8'h10};
    push_frame(owcrc_pkg::KIND_SCRATCHPAD, body, 1'b0);
    // most positive reading, legacy format
    body = {8'hff, 8'h7f, 8'h4b, 8'h46, 8'h7f, 8'hff, 8'h0c, 8'h10};
    push_frame(owcrc_pkg::KIND_SCRATCHPAD, body, 1'b0);
    // plain frame with a wrong CRC
    body = {8'hff, 8'h00};
    push_frame(owcrc_pkg::KIND_PLAIN, body, 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    byte_q_t body;
    gap_pct   = 0;
    stall_pct = 0;
    hold_tog <= ~hold_tog;
    for (int f = 0; f < 3; f++) begin
      body = {};
      repeat (8) body.push_back(8'($urandom_range(255)));
      push_frame(owcrc_pkg::KIND_SCRATCHPAD, body, 1'b0);
    end
    drain_results();
  endtask

  task automatic test_random_phase(input int gap, input int stall, input int n_items);
    byte_q_t body;
    int      stop_at;
    int      pick;
    int      len;
    logic    kind;
    logic    spoil;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick  = $urandom_range(99);
      kind  = owcrc_pkg::KIND_SCRATCHPAD;
      spoil = 1'b0;
      len   = 8;
      if (pick < 55) begin
        spoil = 1'b0;
      end else if (pick < 65) begin
        spoil = 1'b1;
      end else if (pick < 75) begin
        len   = $urandom_range(0, 20);
        spoil = 1'($urandom_range(1));
      end else if (pick < 92) begin
        kind  = owcrc_pkg::KIND_PLAIN;
        len   = $urandom_range(0, 12);
        spoil = ($urandom_range(9) == 0);
      end else begin
        kind  = owcrc_pkg::KIND_PLAIN;
        len   = $urandom_range(13, 24);
        spoil = 1'($urandom_range(1));
      end
      body = {};
      repeat (len) body.push_back(8'($urandom_range(255)));
      push_frame(kind, body, spoil);
    end
    drain_results();
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen  <= hold_tog;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.crc_ok) begin
          note_mismatch("crc_ok", out_tdata[0], want.crc_ok);
        end
        if (out_tdata[1] !== want.length_ok) begin
          note_mismatch("length_ok", out_tdata[1], want.length_ok);
        end
        if (out_tdata[20:2] !== want.temperature) begin
          note_mismatch("temperature", $signed(out_tdata[20:2]), want.temperature);
        end
        if (out_tdata[21] !== want.temp_valid) begin
          note_mismatch("temp_valid", out_tdata[21], want.temp_valid);
        end
      end
    end
  end

  // Watchdog: cycles without any accepted request on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout waiting for a handshake", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 200);
    test_random_phase(64, 0, 200);
    test_random_phase(0, 64, 200);
    test_random_phase(26, 26, 200);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
